[hdl/cee_pkg.sv]
// shared types, constants and tables for the covariance ellipse estimator
// used by cee_isqrt and covariance_ellipse_estimator; no dependencies
package cee_pkg;

    // cordic and datapath sizing
    localparam int CORDIC_ITERS = 16;
    localparam int XW    = 44;          // cordic x/y width, signed
    localparam int ZW    = 34;          // cordic angle width, signed, 2^-32 turn
    localparam int RW    = 43;          // projected spread width
    localparam int SW    = 41;          // trace width, Q.8
    localparam int RADW  = 50;          // radicand width, Q.16
    localparam int SIGW  = RADW / 2;    // sigma width, Q.8
    localparam int REMW  = SIGW + 4;    // root remainder width
    localparam int PRODW = 63;          // gain correction product width
    localparam int MULW  = 16 + SIGW;   // size product width

    localparam logic [19:0] INV_GAIN_Q20 = 20'd636750;
    localparam logic [20:0] LEN_MAX      = 21'd2097151;
    localparam logic signed [ZW-1:0] ANG_HALF    = ZW'(64'sd2147483648);
    localparam logic signed [ZW-1:0] ANG_QUARTER = ZW'(64'sd1073741824);
    localparam logic [15:0] ANG_OFFSET = 16'd23040;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_TAB [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DEGEN  = 2'd1,
        ST_NEGVAR = 2'd2
    } status_t;

    // context that travels with an item down the pipeline
    typedef struct packed {
        status_t        status;
        logic [15:0]    center_x;
        logic [15:0]    center_y;
        logic           b_zero;
        logic           a_neg;
        logic [XW-1:0]  a_abs;
        logic [SW-1:0]  s16;
        logic [15:0]    angle_deg;
    } pay_t;

endpackage

[hdl/cee_isqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on cee_pkg for RADW, SIGW and REMW
module cee_isqrt (
    input  logic                     clk,
    input  logic                     en,
    input  logic [cee_pkg::RADW-1:0] rad,
    output logic [cee_pkg::SIGW-1:0] root
);
    import cee_pkg::*;

    logic [RADW-1:0] rad_reg  [SIGW];
    logic [REMW-1:0] rem_reg  [SIGW];
    logic [SIGW-1:0] root_reg [SIGW];

    genvar j;
    generate
        for (j = 0; j < SIGW; j++)
        begin : g_step
            logic [RADW-1:0] rad_in;
            logic [REMW-1:0] rem_in;
            logic [SIGW-1:0] root_in;
            logic [REMW-1:0] rem_t;
            logic [REMW-1:0] trial;

            // stage inputs: port for the first stage, previous stage otherwise
            if (j == 0)
            begin : g_first
                assign rad_in  = rad;
                assign rem_in  = '0;
                assign root_in = '0;
            end
            else
            begin : g_next
                assign rad_in  = rad_reg[j-1];
                assign rem_in  = rem_reg[j-1];
                assign root_in = root_reg[j-1];
            end

            // bring down two radicand bits and try the next root bit
            assign rem_t = {rem_in[REMW-3:0], rad_in[RADW-1 -: 2]};
            assign trial = {{(REMW-2-SIGW){1'b0}}, root_in, 2'b01};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[j] <= rad_in << 2;
                    if (rem_t >= trial)
                    begin
                        rem_reg[j]  <= rem_t - trial;
                        root_reg[j] <= {root_in[SIGW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[j]  <= rem_t;
                        root_reg[j] <= {root_in[SIGW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[SIGW-1];

endmodule

[hdl/covariance_ellipse_estimator.sv]
// covariance error ellipse: top level, cordic pipeline and output stage
// depends on cee_pkg and cee_isqrt
//
// One request enters per clock unless the pipeline holds; each result passes
// through one input register, one cordic step per stage, three stages for
// gain correction, angle scaling and radicands, 25 square-root stages (one
// bit each, both axes in parallel), one multiply stage and the output
// register. The pipeline moves as a whole: it holds only while a result sits
// in the output register and is not taken. Status goes on m_tuser; non-ok
// results carry zero geometry. The sigma gain may be written only while no
// request is in flight.
module covariance_ellipse_estimator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,      // sigma gain, unsigned q4.12
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,       // var_x, covar_xy, var_y, mean_x, mean_y
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,       // center_x, center_y, angle_deg, width, height
    output logic [1:0]   m_tuser        // status
);
    import cee_pkg::*;

    localparam int IC0 = 0;                 // input register
    localparam int IP1 = CORDIC_ITERS + 1;  // phi clamp, gain product
    localparam int IP2 = IP1 + 1;           // r and angle
    localparam int IP3 = IP2 + 1;           // radicands
    localparam int ISQ = IP3 + SIGW;        // root out
    localparam int IM  = ISQ + 1;           // size products
    localparam int NST = IM + 2;            // plus output register

    logic        en;
    logic [15:0] sigma_gain_reg;
    logic [NST-1:0] vld_reg;
    pay_t        pay_reg  [NST];
    pay_t        pay_next [NST];

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sigma_gain_reg <= 16'd4096;
        else if (cfg_valid)
            sigma_gain_reg <= cfg_data;
    end

    // pipeline advance
    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    // input decode, status and cordic pre-rotation
    logic signed [31:0]   vx, cxy, vy;
    logic signed [XW-1:0] a_in, b_in;
    logic signed [XW-1:0] x0, y0;
    logic signed [ZW-1:0] z0;
    status_t              st_in;
    logic [32:0]          sum_v;

    assign vx  = s_tdata[31:0];
    assign cxy = s_tdata[63:32];
    assign vy  = s_tdata[95:64];
    assign a_in  = XW'($signed({vx[31], vx}) - $signed({vy[31], vy})) <<< 8;
    assign b_in  = -(XW'(cxy) <<< 9);
    assign sum_v = {1'b0, vx} + {1'b0, vy};

    always_comb
    begin
        if (vx <= 0 && vy <= 0)
            st_in = ST_DEGEN;
        else if (vx < 0 || vy < 0)
            st_in = ST_NEGVAR;
        else
            st_in = ST_OK;

        if (!a_in[XW-1])
        begin
            x0 = a_in;
            y0 = b_in;
            z0 = '0;
        end
        else if (!b_in[XW-1] && b_in != 0)
        begin
            x0 = b_in;
            y0 = -a_in;
            z0 = ANG_QUARTER;
        end
        else
        begin
            x0 = -b_in;
            y0 = a_in;
            z0 = -ANG_QUARTER;
        end
    end

    // context chain
    logic [15:0] angle_p2;
    always_comb
    begin
        pay_next[IC0].status    = st_in;
        pay_next[IC0].center_x  = s_tdata[111:96];
        pay_next[IC0].center_y  = s_tdata[127:112];
        pay_next[IC0].b_zero    = (cxy == 0);
        pay_next[IC0].a_neg     = a_in[XW-1];
        pay_next[IC0].a_abs     = a_in[XW-1] ? -a_in : a_in;
        pay_next[IC0].s16       = SW'({sum_v, 8'd0});
        pay_next[IC0].angle_deg = '0;
        for (int k = 1; k < NST; k++)
            pay_next[k] = pay_reg[k-1];
        pay_next[IP2].angle_deg = angle_p2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
                pay_reg[k] <= pay_next[k];
        end
    end

    // cordic vectoring stages
    logic signed [XW-1:0] x_reg [CORDIC_ITERS+1];
    logic signed [XW-1:0] y_reg [CORDIC_ITERS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_ITERS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            z_reg[0] <= z0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_ITERS; i++)
        begin : g_cordic
            logic signed [XW-1:0] dx, dy;
            logic signed [ZW-1:0] da;
            assign dx = x_reg[i] >>> i;
            assign dy = y_reg[i] >>> i;
            assign da = ZW'(ATAN_TAB[i]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!y_reg[i][XW-1])
                    begin
                        x_reg[i+1] <= x_reg[i] + dy;
                        y_reg[i+1] <= y_reg[i] - dx;
                        z_reg[i+1] <= z_reg[i] + da;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - dy;
                        y_reg[i+1] <= y_reg[i] + dx;
                        z_reg[i+1] <= z_reg[i] - da;
                    end
                end
            end
        end
    endgenerate

    // phi select and clamp, gain correction product
    logic signed [ZW-1:0] phi_next, phi_reg;
    logic [PRODW-1:0]     prod_reg;
    pay_t                 p_c;
    assign p_c = pay_reg[CORDIC_ITERS];

    always_comb
    begin
        if (p_c.b_zero)
            phi_next = p_c.a_neg ? -ANG_HALF : '0;
        else if (z_reg[CORDIC_ITERS] > ANG_HALF)
            phi_next = ANG_HALF;
        else if (z_reg[CORDIC_ITERS] < -ANG_HALF)
            phi_next = -ANG_HALF;
        else
            phi_next = z_reg[CORDIC_ITERS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg  <= phi_next;
            prod_reg <= PRODW'(x_reg[CORDIC_ITERS][XW-2:0]) * PRODW'(INV_GAIN_Q20);
        end
    end

    // spread r and angle in degrees
    logic [RW-1:0]   r_reg;
    logic [PRODW-1:0] prod_rnd;
    logic [ZW-1:0]   phi_off;
    logic [38:0]     ang_scaled;
    pay_t            p_1;
    assign p_1        = pay_reg[IP1];
    assign prod_rnd   = prod_reg + PRODW'(64'd524288);
    assign phi_off    = ZW'(phi_reg + ANG_HALF);
    assign ang_scaled = 39'(phi_off[32:0]) * 39'd45 + 39'd2097152;
    assign angle_p2   = ang_scaled[37:22] - ANG_OFFSET;

    always_ff @(posedge clk)
    begin
        if (en)
            r_reg <= p_1.b_zero ? RW'(p_1.a_abs) : prod_rnd[RW+19:20];
    end

    // radicands for both axes in Q.16
    logic [RADW-1:0] rad_x_reg, rad_y_reg;
    logic [RW:0]     s_ext, diff, sum_sr;
    pay_t            p_2;
    assign p_2    = pay_reg[IP2];
    assign s_ext  = (RW+1)'(p_2.s16);
    assign diff   = (s_ext >= {1'b0, r_reg}) ? s_ext - {1'b0, r_reg}
                                             : {1'b0, r_reg} - s_ext;
    assign sum_sr = s_ext + {1'b0, r_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_x_reg <= RADW'({diff, 7'd0});
            rad_y_reg <= RADW'({sum_sr, 7'd0});
        end
    end

    // square roots
    logic [SIGW-1:0] sig_x, sig_y;
    cee_isqrt u_sqrt_x (.clk(clk), .en(en), .rad(rad_x_reg), .root(sig_x));
    cee_isqrt u_sqrt_y (.clk(clk), .en(en), .rad(rad_y_reg), .root(sig_y));

    // size multiply
    logic [MULW-1:0] mul_x_reg, mul_y_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_x_reg <= MULW'(sigma_gain_reg) * MULW'(sig_x);
            mul_y_reg <= MULW'(sigma_gain_reg) * MULW'(sig_y);
        end
    end

    // round, saturate, and zero geometry unless ok
    logic [MULW:0] rnd_x, rnd_y;
    logic [20:0]   len_x, len_y;
    logic [20:0]   width_reg, height_reg;
    pay_t          p_m;
    assign p_m   = pay_reg[IM];
    assign rnd_x = {1'b0, mul_x_reg} + (MULW+1)'(262144);
    assign rnd_y = {1'b0, mul_y_reg} + (MULW+1)'(262144);
    assign len_x = (rnd_x[MULW:19] > (MULW-18)'(LEN_MAX)) ? LEN_MAX : rnd_x[39:19];
    assign len_y = (rnd_y[MULW:19] > (MULW-18)'(LEN_MAX)) ? LEN_MAX : rnd_y[39:19];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            width_reg  <= (p_m.status == ST_OK) ? len_x : '0;
            height_reg <= (p_m.status == ST_OK) ? len_y : '0;
        end
    end

    // result port
    pay_t p_o;
    logic ok_o;
    assign p_o     = pay_reg[NST-1];
    assign ok_o    = (p_o.status == ST_OK);
    assign m_tuser = p_o.status;
    assign m_tdata = {6'd0, height_reg, width_reg,
                      ok_o ? p_o.angle_deg : 16'd0,
                      ok_o ? p_o.center_y : 16'd0,
                      ok_o ? p_o.center_x : 16'd0};

    // non-ok results carry no geometry
    a_zero_geom: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[89:0] == '0))
        else $error("geometry not cleared on non-ok status");

    // ok angle stays within a half turn
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_OK) |->
        ($signed(m_tdata[47:32]) >= -16'sd23040 && $signed(m_tdata[47:32]) <= 16'sd23040))
        else $error("angle out of range");

    // a held result keeps its status while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser) && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

[bench/covariance_ellipse_estimator_tb.sv]
// testbench for the covariance ellipse estimator: random and directed covariance requests,
// results checked against an in-bench fixed-point cordic prediction
// depends on cee_pkg and the covariance_ellipse_estimator rtl
module covariance_ellipse_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cee_pkg::*;

    localparam int PIPE_LAT = 60;

    typedef struct packed {
        logic [15:0] mean_y;
        logic [15:0] mean_x;
        logic [31:0] var_y;
        logic [31:0] covar_xy;
        logic [31:0] var_x;
    } cov_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] angle_deg;
        logic [20:0] width;
        logic [20:0] height;
    } ellipse_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    covariance_ellipse_estimator u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    cov_req_t   pending_reqs[$];
    ellipse_t   expected_ellipses[$];
    logic [15:0] k_coef;
    int          errors = 0;
    bit          quiet_tail;
    bit          send_hold;
    bit          hold_start;
    int          sink_hold;
    int          src_gap;
    int          sink_gap;

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // floor division by 2^s
    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v - 1) >>> s) - 1;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [20:0] axis_length(longint unsigned rad, logic [15:0] k);
        longint unsigned sig;
        longint unsigned len;
        sig = root_floor(rad);
        len = (longint'(k) * sig + (64'd1 << 18)) >> 19;
        return (len > 64'd2097151) ? 21'd2097151 : len[20:0];
    endfunction

    // ellipse geometry from one covariance request
    function automatic ellipse_t predict_ellipse(cov_req_t q, logic [15:0] k);
        ellipse_t e;
        longint vx, cxy, vy, a, b, phi, x, y, z, dx, dy, s16, diff, ang;
        longint unsigned r;
        e = '0;
        vx = longint'(signed'(q.var_x));
        cxy = longint'(signed'(q.covar_xy));
        vy = longint'(signed'(q.var_y));
        a = (vx - vy) * 256;
        b = -2 * cxy * 256;
        if (vx <= 0 && vy <= 0)
        begin
            e.status = ST_DEGEN;
            return e;
        end
        if (vx < 0 || vy < 0)
        begin
            e.status = ST_NEGVAR;
            return e;
        end
        if (b == 0)
        begin
            phi = (a >= 0) ? 0 : -64'sd2147483648;
            r = (a >= 0) ? a : -a;
        end
        else
        begin
            if (a >= 0)
            begin
                x = a; y = b; z = 0;
            end
            else if (b > 0)
            begin
                x = b; y = -a; z = 64'sd1073741824;
            end
            else
            begin
                x = -b; y = a; z = -64'sd1073741824;
            end
            for (int i = 0; i < CORDIC_ITERS && i < 24; i++)
            begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (y >= 0)
                begin
                    x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
                end
                else
                begin
                    x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
                end
            end
            phi = z;
            if (phi > 64'sd2147483648) phi = 64'sd2147483648;
            if (phi < -64'sd2147483648) phi = -64'sd2147483648;
            r = (longint'(x) * 636750 + (64'd1 << 19)) >> 20;
        end
        ang = (phi * 45 + (64'sd1 << 21) + 45 * 64'sd2147483648) >>> 22;
        s16 = (vx + vy) * 256;
        diff = s16 - longint'(r);
        if (diff < 0)
            diff = -diff;
        e.status = ST_OK;
        e.center_x = q.mean_x;
        e.center_y = q.mean_y;
        e.angle_deg = 16'(ang - 23040);
        e.width = axis_length(longint'(diff) * 128, k);
        e.height = axis_length((longint'(s16) + r) * 128, k);
        return e;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            src_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0 && !send_hold)
            begin
                s_tdata <= pending_reqs[0];
                expected_ellipses.push_back(predict_ellipse(pending_reqs[0], k_coef));
                void'(pending_reqs.pop_front());
                s_tvalid <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 9) == 0)
                    src_gap <= $urandom_range(1, 16);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        ellipse_t got;
        ellipse_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                       m_tdata[68:48], m_tdata[89:69]};
                if (expected_ellipses.size() == 0)
                begin
                    $display("%0t: result with none expected: %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_ellipses.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                        errors++;
                    end
                    if (got.center_x !== want.center_x)
                    begin
                        $display("%0t: center_x exp %h got %h", $time,
                                 want.center_x, got.center_x);
                        errors++;
                    end
                    if (got.center_y !== want.center_y)
                    begin
                        $display("%0t: center_y exp %h got %h", $time,
                                 want.center_y, got.center_y);
                        errors++;
                    end
                    if (got.angle_deg !== want.angle_deg)
                    begin
                        $display("%0t: angle_deg exp %h got %h", $time,
                                 want.angle_deg, got.angle_deg);
                        errors++;
                    end
                    if (got.width !== want.width)
                    begin
                        $display("%0t: width exp %h got %h", $time, want.width, got.width);
                        errors++;
                    end
                    if (got.height !== want.height)
                    begin
                        $display("%0t: height exp %h got %h", $time, want.height, got.height);
                        errors++;
                    end
                end
            end
            if (sink_hold > 0)
                m_tready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                sink_gap <= $urandom_range(0, 15);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sink_hold <= 0;
        else if (hold_start)
            sink_hold <= 400;
        else if (sink_hold > 0)
            sink_hold <= sink_hold - 1;
    end

    function automatic logic [31:0] rand_var();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 255);
            2: return $urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom_range(1, 32'h7FFF_FFFF);
        endcase
    endfunction

    function automatic logic [31:0] rand_covar();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh00FF_FFFF);
            default: return 32'($signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh3FFF_FFFF);
        endcase
    endfunction

    task automatic add_req(logic [31:0] vx, logic [31:0] cxy, logic [31:0] vy);
        cov_req_t q;
        q.var_x = vx;
        q.covar_xy = cxy;
        q.var_y = vy;
        q.mean_x = $urandom();
        q.mean_y = $urandom();
        pending_reqs.push_back(q);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_ellipses.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    task automatic write_coef(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        k_coef = v;
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++)
            add_req(rand_var(), rand_covar(), rand_var());
    endtask

    // stimulus
    initial
    begin
        logic [15:0] coefs[5];
        quiet_tail = 1'b0;
        send_hold = 1'b0;
        hold_start = 1'b0;
        k_coef = 16'd4096;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, both non-ok kinds, zero cross term, indefinite
        add_req(32'd0, 32'd0, 32'd0);
        add_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_req(32'hFFFF_FFFF, 32'd5, 32'd0);
        add_req(32'd100, 32'd0, 32'hFFFF_FF00);
        add_req(32'h8000_0000, 32'd0, 32'd1);
        add_req(32'd1, 32'd0, 32'd0);
        add_req(32'd0, 32'd0, 32'd1);
        add_req(32'd1000, 32'd0, 32'd1000);
        add_req(32'd500, 32'd0, 32'd2000);
        add_req(32'd2000, 32'd0, 32'd500);
        add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_req(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
        add_req(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_req(32'd1, 32'd1000, 32'd1);
        add_req(32'd1, 32'hFFFF_FC18, 32'd1);
        add_req(32'd300, 32'd200, 32'd100);
        add_req(32'd100, 32'hFFFF_FF38, 32'd300);
        add_req(32'd256, 32'd256, 32'd0);
        begin
            cov_req_t q;
            q = {16'hFFFF, 16'hFFFF, 32'd256, 32'd0, 32'd256};
            pending_reqs.push_back(q);
            q = {16'h0000, 16'h0000, 32'd256, 32'd0, 32'd256};
            pending_reqs.push_back(q);
        end
        wait_drained();

        // several coefficient settings, extremes included
        coefs = '{16'hFFFF, 16'd1, 16'd0, 16'd12288, 16'd4096};
        foreach (coefs[c])
        begin
            write_coef(coefs[c]);
            random_burst(200);
            if (c == 1)
            begin
                // receiver holds off while requests keep coming
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
                random_burst(100);
            end
            if (c == 2)
            begin
                // sender pauses until everything has come back
                while (pending_reqs.size() > 0)
                    @(posedge clk);
                send_hold = 1'b1;
                while (expected_ellipses.size() > 0)
                    @(posedge clk);
                send_hold = 1'b0;
            end
            wait_drained();
        end

        // tail without idling
        quiet_tail = 1'b1;
        random_burst(280);
        wait_drained();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

endmodule
